>>> design/fta_pkg.sv
// ----------------------------------------------------------------------------
// fta_pkg: shared types and constants of the fringe timing averager
// Field widths, divider request/response beats and limits.
// ----------------------------------------------------------------------------
package fta_pkg;

   localparam int MAX_BLOCK_DEF = 16;

   localparam int RAW_W   = 16;
   localparam int TUS_W   = 16;
   localparam int AVG_W   = 24;
   localparam int CORR_W  = 24;
   localparam int SUM_W   = 32;
   localparam int SQSUM_W = 56;
   localparam int JIT_W   = 24;
   localparam int HOP_W   = 16;

   localparam int DIV_NW  = 64;
   localparam int DIV_DW  = 25;
   localparam int DIV_CW  = 7;

   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 160;

   localparam logic [5:0] CLK_DIV_MIN = 6'd5;

   localparam logic CSR_CLOCK_QUARTER_MHZ = 1'b0;
   localparam logic CSR_BLOCK_LENGTH      = 1'b1;

   typedef struct packed {
      logic                start;
      logic [DIV_NW-1:0]   dividend;
      logic [DIV_DW-1:0]   divisor;
      logic [DIV_CW-1:0]   nbits;
   } fta_div_req_type;

   typedef struct packed {
      logic                done;
      logic [DIV_NW-1:0]   quotient;
   } fta_div_rsp_type;

endpackage

>>> design/fta_ram.sv
// ----------------------------------------------------------------------------
// fta_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module fta_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> design/fta_div.sv
// ----------------------------------------------------------------------------
// fta_div: shared iterative unsigned divider
// Restoring division, one quotient bit per cycle over nbits dividend bits.
// ----------------------------------------------------------------------------
module fta_div import fta_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  fta_div_req_type div_req,
   output fta_div_rsp_type div_rsp
);

   logic              act_ff, act_in;
   logic              done_ff, done_in;
   logic [DIV_CW-1:0] cnt_ff, cnt_in;
   logic [DIV_NW-1:0] num_ff, num_in;
   logic [DIV_DW-1:0] den_ff, den_in;
   logic [DIV_DW-1:0] rem_ff, rem_in;
   logic [DIV_NW-1:0] quo_ff, quo_in;

   logic [DIV_CW-1:0] cnt_m1;
   logic [DIV_DW:0]   trial;
   logic [DIV_DW:0]   diff;
   logic              ge;

   always_comb begin
      cnt_m1  = cnt_ff - 1'b1;
      trial   = {rem_ff, num_ff[cnt_m1[DIV_CW-2:0]]};
      ge      = (trial >= {1'b0, den_ff});
      diff    = trial - {1'b0, den_ff};
      act_in  = act_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (div_req.start) begin
         act_in = 1'b1;
         cnt_in = div_req.nbits;
         num_in = div_req.dividend;
         den_in = div_req.divisor;
         rem_in = '0;
         quo_in = '0;
      end else if (act_ff) begin
         rem_in = ge ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
         quo_in = {quo_ff[DIV_NW-2:0], ge};
         cnt_in = cnt_m1;
         if (cnt_ff == DIV_CW'(1)) begin
            act_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         act_ff  <= act_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

>>> design/fringe_timing_averager.sv
// ----------------------------------------------------------------------------
// fringe_timing_averager: ramp timing filter and block averager
// Scales raw fringe counter values, rejects outliers, tracks hops and
// reports block means, jitter and hop counts.
// ----------------------------------------------------------------------------
// Usage:
//   req_* takes one ramp beat (four raw 16-bit counts). req_tready is high
//   only while the sequencer is idle. rsp_* carries one result beat per
//   closed block with more than one accepted ramp; rsp_tuser is the data
//   valid flag. csr_* writes clock_quarter_mhz (index 0) and block_length
//   (index 1), by the user only while the block is idle; it is not enforced.
//   Sequencing: all divisions run on one shared bit-serial divider and the
//   square root on a two-bit-per-cycle unit. After a ramp beat req_tready
//   stays low while the four raw counts are scaled by division, and for an
//   accepted ramp also through two 49-bit mean updates. Closing a block
//   adds four 32-bit mean divisions, a read, subtract and accumulate pass
//   over the n accepted ramps, two 64-bit variance divisions each followed
//   by a square root, and the output state.
//   Reset clears the control state, averages, hop counts and block sums;
//   the sample store is not cleared. A result waiting in the output
//   register does not block new ramps; the next closing block waits in its output state until that beat is taken.
// ----------------------------------------------------------------------------
module fringe_timing_averager import fta_pkg::*; #(
   parameter int MAX_BLOCK = MAX_BLOCK_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // raw_offset_ref, raw_offset_diode, raw_inter_ref, raw_inter_diode
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // mean_offset_ref, mean_offset_diode, mean_inter_ref, mean_inter_diode,
   // jitter_ref, jitter_diode, fsr_ref_start, fsr_diode_start, zero pad
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // data_valid
   output logic                  rsp_tuser,
   input  logic                  csr_we,
   input  logic                  csr_index,
   input  logic [5:0]            csr_wdata
);

   localparam int CW = $clog2(MAX_BLOCK + 1);
   localparam int AW = $clog2(MAX_BLOCK);

   typedef enum logic [18:0] {
      ST_IDLE  = 19'h00001,
      ST_TUS   = 19'h00002,
      ST_EVAL  = 19'h00004,
      ST_CORR  = 19'h00008,
      ST_MEANR = 19'h00010,
      ST_MEAND = 19'h00020,
      ST_STEP  = 19'h00040,
      ST_MOFR  = 19'h00080,
      ST_MOFD  = 19'h00100,
      ST_MINR  = 19'h00200,
      ST_MIND  = 19'h00400,
      ST_JRD   = 19'h00800,
      ST_JSUB  = 19'h01000,
      ST_JACC  = 19'h02000,
      ST_JDIVR = 19'h04000,
      ST_JSQR  = 19'h08000,
      ST_JDIVD = 19'h10000,
      ST_JSQD  = 19'h20000,
      ST_EMIT  = 19'h40000
   } state_type;

   state_type state_ff, state_in;
   logic      iss_ff, iss_in;
   logic [1:0] idx_ff, idx_in;
   logic [RAW_W-1:0] raw_ff [4];
   logic [RAW_W-1:0] raw_in [4];
   logic [TUS_W-1:0] t_ff [4];
   logic [TUS_W-1:0] t_in [4];
   logic [5:0] cqm_ff, cqm_in;
   logic [4:0] blen_ff, blen_in;
   logic [AVG_W-1:0] avg_r_ff, avg_r_in, avg_d_ff, avg_d_in, acc_tot_ff, acc_tot_in;
   logic seeded_ff, seeded_in, block_ok_ff, block_ok_in;
   logic [TUS_W-1:0] prev_r_ff, prev_r_in, prev_d_ff, prev_d_in;
   logic signed [HOP_W-1:0] hops_r_ff, hops_r_in, hops_d_ff, hops_d_in;
   logic signed [HOP_W-1:0] bhops_r_ff, bhops_r_in, bhops_d_ff, bhops_d_in;
   logic [CW-1:0] ramp_ff, ramp_in, acc_ff, acc_in, jidx_ff, jidx_in;
   logic signed [SUM_W-1:0] sum_or_ff, sum_or_in, sum_od_ff, sum_od_in;
   logic [SUM_W-1:0] sum_ir_ff, sum_ir_in, sum_id_ff, sum_id_in;
   logic signed [CORR_W:0] m_r_ff, m_r_in, m_d_ff, m_d_in;
   logic [TUS_W-1:0] mi_r_ff, mi_r_in, mi_d_ff, mi_d_in;
   logic [CORR_W:0] ad_r_ff, ad_r_in, ad_d_ff, ad_d_in;
   logic [SQSUM_W-1:0] ss_r_ff, ss_r_in, ss_d_ff, ss_d_in;
   logic [JIT_W-1:0] jit_r_ff, jit_r_in, jit_d_ff, jit_d_in;
   logic sq_act_ff, sq_act_in;
   logic [4:0] sq_cnt_ff, sq_cnt_in;
   logic [DIV_NW-1:0] sq_val_ff, sq_val_in;
   logic [34:0] sq_rem_ff, sq_rem_in;
   logic [31:0] sq_root_ff, sq_root_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic rsp_user_ff, rsp_user_in;

   fta_div_req_type div_req;
   fta_div_rsp_type div_rsp;

   logic            ram_we;
   logic [2*CORR_W-1:0] ram_wdata, ram_rdata;

   logic [5:0]      dsel;
   logic [CW-1:0]   len_w;
   logic            near_r, near_d;
   logic signed [18:0] dr2, sp_r;
   logic signed [19:0] de2, sp_d;
   logic signed [16:0] dh_r, dh_d;
   logic signed [33:0] prod_r, prod_d;
   logic signed [34:0] cf_r, cf_d;
   logic signed [CORR_W-1:0] c_r, c_d;
   logic [47:0] mprod;
   logic [31:0] abs_sum;
   logic [CW-1:0] ramp_nx;
   logic signed [CORR_W+1:0] dj_r, dj_d;
   logic [34:0] sq_sh, sq_trial;

   function automatic logic near_mean(input logic [TUS_W-1:0] t, input logic [AVG_W-1:0] avg);
      logic signed [AVG_W:0] dev;
      logic [AVG_W-1:0] adev;
      logic [AVG_W+3:0] dev10;
      dev   = $signed({1'b0, t, 8'b0}) - $signed({1'b0, avg});
      adev  = dev[AVG_W] ? AVG_W'(-dev) : dev[AVG_W-1:0];
      dev10 = {4'b0, adev} * 28'd10;
      return dev10 < {4'b0, avg};
   endfunction

   function automatic logic signed [CORR_W-1:0] sat_corr(input logic signed [34:0] v);
      if (v > 35'sd8388607) begin
         return 24'sh7FFFFF;
      end else if (v < -35'sd8388608) begin
         return 24'sh800000;
      end
      return v[CORR_W-1:0];
   endfunction

   function automatic logic [20:0] sat_mean(input logic signed [CORR_W:0] v);
      if (v > 25'sd1048575) begin
         return 21'h0FFFFF;
      end else if (v < -25'sd1048576) begin
         return 21'h100000;
      end
      return v[20:0];
   endfunction

   function automatic logic [JIT_W-1:0] sat_jit(input logic [31:0] v);
      return (|v[31:JIT_W]) ? {JIT_W{1'b1}} : v[JIT_W-1:0];
   endfunction

   function automatic logic signed [HOP_W-1:0] hop_dec(input logic signed [HOP_W-1:0] h);
      return (h == -16'sd32768) ? h : h - 16'sd1;
   endfunction

   function automatic logic signed [HOP_W-1:0] hop_inc(input logic signed [HOP_W-1:0] h);
      return (h == 16'sd32767) ? h : h + 16'sd1;
   endfunction

   always_comb begin
      dsel = (cqm_ff < CLK_DIV_MIN) ? CLK_DIV_MIN : cqm_ff;
      if (blen_ff < 5'd2) begin
         len_w = CW'(2);
      end else if (int'(blen_ff) > MAX_BLOCK) begin
         len_w = CW'(MAX_BLOCK);
      end else begin
         len_w = CW'(blen_ff);
      end
      near_r = near_mean(t_ff[2], avg_r_ff);
      near_d = near_mean(t_ff[3], avg_d_ff);
      dr2  = ($signed({3'b0, t_ff[0]}) - $signed({3'b0, prev_r_ff})) <<< 1;
      sp_r = $signed({3'b0, t_ff[2]});
      de2  = (($signed({4'b0, t_ff[1]}) - $signed({4'b0, t_ff[0]}))
            - ($signed({4'b0, prev_d_ff}) - $signed({4'b0, prev_r_ff}))) <<< 1;
      sp_d = $signed({4'b0, t_ff[3]});
      dh_r = 17'(hops_r_ff) - 17'(bhops_r_ff);
      dh_d = 17'(hops_d_ff) - 17'(bhops_d_ff);
      prod_r = dh_r * $signed({1'b0, t_ff[2]});
      prod_d = dh_d * $signed({1'b0, t_ff[3]});
      cf_r = 35'(prod_r) + 35'($signed({1'b0, t_ff[0]}));
      cf_d = 35'(prod_d) + 35'($signed({1'b0, t_ff[1]}));
      c_r  = sat_corr(cf_r);
      c_d  = sat_corr(cf_d);
      mprod = (state_ff == ST_MEANR) ? avg_r_ff * acc_tot_ff : avg_d_ff * acc_tot_ff;
      if (state_ff == ST_MOFR) begin
         abs_sum = sum_or_ff[SUM_W-1] ? 32'(-sum_or_ff) : 32'(sum_or_ff);
      end else begin
         abs_sum = sum_od_ff[SUM_W-1] ? 32'(-sum_od_ff) : 32'(sum_od_ff);
      end
      ramp_nx = ramp_ff + 1'b1;
      dj_r = 26'($signed(ram_rdata[CORR_W-1:0])) - 26'(m_r_ff);
      dj_d = 26'($signed(ram_rdata[2*CORR_W-1:CORR_W])) - 26'(m_d_ff);
      sq_sh    = {sq_rem_ff[32:0], sq_val_ff[DIV_NW-1:DIV_NW-2]};
      sq_trial = {1'b0, sq_root_ff, 2'b01};
   end

   always_comb begin
      state_in = state_ff;
      iss_in = iss_ff;
      idx_in = idx_ff;
      raw_in = raw_ff;
      t_in = t_ff;
      cqm_in = cqm_ff;
      blen_in = blen_ff;
      avg_r_in = avg_r_ff;
      avg_d_in = avg_d_ff;
      acc_tot_in = acc_tot_ff;
      seeded_in = seeded_ff;
      block_ok_in = block_ok_ff;
      prev_r_in = prev_r_ff;
      prev_d_in = prev_d_ff;
      hops_r_in = hops_r_ff;
      hops_d_in = hops_d_ff;
      bhops_r_in = bhops_r_ff;
      bhops_d_in = bhops_d_ff;
      ramp_in = ramp_ff;
      acc_in = acc_ff;
      jidx_in = jidx_ff;
      sum_or_in = sum_or_ff;
      sum_od_in = sum_od_ff;
      sum_ir_in = sum_ir_ff;
      sum_id_in = sum_id_ff;
      m_r_in = m_r_ff;
      m_d_in = m_d_ff;
      mi_r_in = mi_r_ff;
      mi_d_in = mi_d_ff;
      ad_r_in = ad_r_ff;
      ad_d_in = ad_d_ff;
      ss_r_in = ss_r_ff;
      ss_d_in = ss_d_ff;
      jit_r_in = jit_r_ff;
      jit_d_in = jit_d_ff;
      sq_act_in = sq_act_ff;
      sq_cnt_in = sq_cnt_ff;
      sq_val_in = sq_val_ff;
      sq_rem_in = sq_rem_ff;
      sq_root_in = sq_root_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in = rsp_data_ff;
      rsp_user_in = rsp_user_ff;
      div_req = '0;
      ram_we = 1'b0;
      ram_wdata = {c_d, c_r};

      if (csr_we) begin
         if (csr_index == CSR_CLOCK_QUARTER_MHZ) begin
            cqm_in = csr_wdata;
         end else begin
            blen_in = csr_wdata[4:0];
         end
      end

      if (sq_act_ff) begin
         if (sq_sh >= sq_trial) begin
            sq_rem_in  = sq_sh - sq_trial;
            sq_root_in = {sq_root_ff[30:0], 1'b1};
         end else begin
            sq_rem_in  = sq_sh;
            sq_root_in = {sq_root_ff[30:0], 1'b0};
         end
         sq_val_in = {sq_val_ff[DIV_NW-3:0], 2'b00};
         sq_cnt_in = sq_cnt_ff - 1'b1;
         if (sq_cnt_ff == 5'd0) begin
            sq_act_in = 1'b0;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               for (int i = 0; i < 4; i++) begin
                  raw_in[i] = req_tdata[i*RAW_W +: RAW_W];
               end
               idx_in = 2'd0;
               state_in = ST_TUS;
            end
         end
         ST_TUS: begin
            if (!iss_ff) begin
               div_req.start    = 1'b1;
               div_req.dividend = DIV_NW'({raw_ff[idx_ff], 2'b00});
               div_req.divisor  = DIV_DW'(dsel);
               div_req.nbits    = DIV_CW'(RAW_W + 2);
               iss_in = 1'b1;
            end else if (div_rsp.done) begin
               iss_in = 1'b0;
               t_in[idx_ff] = div_rsp.quotient[TUS_W-1:0];
               idx_in = idx_ff + 1'b1;
               if (idx_ff == 2'd3) begin
                  state_in = ST_EVAL;
               end
            end
         end
         ST_EVAL: begin
            if (!seeded_ff) begin
               avg_r_in = {t_ff[2], 8'b0};
               avg_d_in = {t_ff[3], 8'b0};
               prev_r_in = t_ff[0];
               prev_d_in = t_ff[1];
               seeded_in = 1'b1;
               block_ok_in = 1'b0;
               state_in = ST_STEP;
            end else if (near_r && near_d) begin
               if (dr2 > sp_r) begin
                  hops_r_in = hop_dec(hops_r_ff);
               end else if (dr2 < -sp_r) begin
                  hops_r_in = hop_inc(hops_r_ff);
               end else if (de2 > sp_d) begin
                  hops_d_in = hop_dec(hops_d_ff);
               end else if (de2 < -sp_d) begin
                  hops_d_in = hop_inc(hops_d_ff);
               end
               state_in = ST_CORR;
            end else begin
               block_ok_in = 1'b0;
               state_in = ST_STEP;
            end
         end
         ST_CORR: begin
            if (int'(acc_ff) < MAX_BLOCK) begin
               ram_we = 1'b1;
               acc_in = acc_ff + 1'b1;
               sum_or_in = sum_or_ff + SUM_W'(c_r);
               sum_od_in = sum_od_ff + SUM_W'(c_d);
               sum_ir_in = sum_ir_ff + SUM_W'(t_ff[2]);
               sum_id_in = sum_id_ff + SUM_W'(t_ff[3]);
            end
            prev_r_in = t_ff[0];
            prev_d_in = t_ff[1];
            if (acc_tot_ff != {AVG_W{1'b1}}) begin
               acc_tot_in = acc_tot_ff + 1'b1;
            end
            state_in = ST_MEANR;
         end
         ST_MEANR, ST_MEAND: begin
            if (!iss_ff) begin
               div_req.start    = 1'b1;
               div_req.dividend = DIV_NW'(mprod) + DIV_NW'({(state_ff == ST_MEANR) ?
                                  t_ff[2] : t_ff[3], 8'b0});
               div_req.divisor  = DIV_DW'(acc_tot_ff) + 1'b1;
               div_req.nbits    = DIV_CW'(2 * AVG_W + 1);
               iss_in = 1'b1;
            end else if (div_rsp.done) begin
               iss_in = 1'b0;
               if (state_ff == ST_MEANR) begin
                  avg_r_in = div_rsp.quotient[AVG_W-1:0];
                  state_in = ST_MEAND;
               end else begin
                  avg_d_in = div_rsp.quotient[AVG_W-1:0];
                  state_in = ST_STEP;
               end
            end
         end
         ST_STEP: begin
            ramp_in = ramp_nx;
            state_in = ST_IDLE;
            if (ramp_nx >= len_w) begin
               if (acc_ff > CW'(1)) begin
                  jidx_in = '0;
                  ss_r_in = '0;
                  ss_d_in = '0;
                  state_in = ST_MOFR;
               end else begin
                  ramp_in = '0;
                  acc_in = '0;
                  block_ok_in = 1'b1;
                  sum_or_in = '0;
                  sum_od_in = '0;
                  sum_ir_in = '0;
                  sum_id_in = '0;
                  bhops_r_in = hops_r_ff;
                  bhops_d_in = hops_d_ff;
               end
            end
         end
         ST_MOFR, ST_MOFD: begin
            if (!iss_ff) begin
               div_req.start    = 1'b1;
               div_req.dividend = DIV_NW'(abs_sum);
               div_req.divisor  = DIV_DW'(acc_ff);
               div_req.nbits    = DIV_CW'(SUM_W);
               iss_in = 1'b1;
            end else if (div_rsp.done) begin
               iss_in = 1'b0;
               if (state_ff == ST_MOFR) begin
                  m_r_in = sum_or_ff[SUM_W-1] ? -$signed(div_rsp.quotient[CORR_W:0])
                                              : $signed(div_rsp.quotient[CORR_W:0]);
                  state_in = ST_MOFD;
               end else begin
                  m_d_in = sum_od_ff[SUM_W-1] ? -$signed(div_rsp.quotient[CORR_W:0])
                                              : $signed(div_rsp.quotient[CORR_W:0]);
                  state_in = ST_MINR;
               end
            end
         end
         ST_MINR, ST_MIND: begin
            if (!iss_ff) begin
               div_req.start    = 1'b1;
               div_req.dividend = DIV_NW'((state_ff == ST_MINR) ? sum_ir_ff : sum_id_ff);
               div_req.divisor  = DIV_DW'(acc_ff);
               div_req.nbits    = DIV_CW'(SUM_W);
               iss_in = 1'b1;
            end else if (div_rsp.done) begin
               iss_in = 1'b0;
               if (state_ff == ST_MINR) begin
                  mi_r_in = div_rsp.quotient[TUS_W-1:0];
                  state_in = ST_MIND;
               end else begin
                  mi_d_in = div_rsp.quotient[TUS_W-1:0];
                  state_in = ST_JRD;
               end
            end
         end
         ST_JRD: begin
            state_in = ST_JSUB;
         end
         ST_JSUB: begin
            ad_r_in = dj_r[CORR_W+1] ? 25'(-dj_r) : dj_r[CORR_W:0];
            ad_d_in = dj_d[CORR_W+1] ? 25'(-dj_d) : dj_d[CORR_W:0];
            state_in = ST_JACC;
         end
         ST_JACC: begin
            ss_r_in = ss_r_ff + SQSUM_W'(ad_r_ff * ad_r_ff);
            ss_d_in = ss_d_ff + SQSUM_W'(ad_d_ff * ad_d_ff);
            jidx_in = jidx_ff + 1'b1;
            state_in = (jidx_ff + 1'b1 == acc_ff) ? ST_JDIVR : ST_JRD;
         end
         ST_JDIVR, ST_JDIVD: begin
            if (!iss_ff) begin
               div_req.start    = 1'b1;
               div_req.dividend = {(state_ff == ST_JDIVR) ? ss_r_ff : ss_d_ff, 8'b0};
               div_req.divisor  = DIV_DW'(acc_ff - 1'b1);
               div_req.nbits    = DIV_CW'(DIV_NW);
               iss_in = 1'b1;
            end else if (div_rsp.done) begin
               iss_in = 1'b0;
               sq_act_in = 1'b1;
               sq_cnt_in = 5'd31;
               sq_val_in = div_rsp.quotient;
               sq_rem_in = '0;
               sq_root_in = '0;
               state_in = (state_ff == ST_JDIVR) ? ST_JSQR : ST_JSQD;
            end
         end
         ST_JSQR: begin
            if (!sq_act_ff) begin
               jit_r_in = sat_jit(sq_root_ff);
               state_in = ST_JDIVD;
            end
         end
         ST_JSQD: begin
            if (!sq_act_ff) begin
               jit_d_in = sat_jit(sq_root_ff);
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = {6'b0, bhops_d_ff, bhops_r_ff, jit_d_ff, jit_r_ff,
                              mi_d_ff, mi_r_ff, sat_mean(m_d_ff), sat_mean(m_r_ff)};
               rsp_user_in = block_ok_ff;
               ramp_in = '0;
               acc_in = '0;
               block_ok_in = 1'b1;
               sum_or_in = '0;
               sum_od_in = '0;
               sum_ir_in = '0;
               sum_id_in = '0;
               bhops_r_in = hops_r_ff;
               bhops_d_in = hops_d_ff;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         iss_ff <= 1'b0;
         cqm_ff <= 6'd5;
         blen_ff <= 5'd10;
         avg_r_ff <= '0;
         avg_d_ff <= '0;
         acc_tot_ff <= '0;
         seeded_ff <= 1'b0;
         block_ok_ff <= 1'b1;
         prev_r_ff <= '0;
         prev_d_ff <= '0;
         hops_r_ff <= '0;
         hops_d_ff <= '0;
         bhops_r_ff <= '0;
         bhops_d_ff <= '0;
         ramp_ff <= '0;
         acc_ff <= '0;
         sum_or_ff <= '0;
         sum_od_ff <= '0;
         sum_ir_ff <= '0;
         sum_id_ff <= '0;
         sq_act_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         iss_ff <= iss_in;
         cqm_ff <= cqm_in;
         blen_ff <= blen_in;
         avg_r_ff <= avg_r_in;
         avg_d_ff <= avg_d_in;
         acc_tot_ff <= acc_tot_in;
         seeded_ff <= seeded_in;
         block_ok_ff <= block_ok_in;
         prev_r_ff <= prev_r_in;
         prev_d_ff <= prev_d_in;
         hops_r_ff <= hops_r_in;
         hops_d_ff <= hops_d_in;
         bhops_r_ff <= bhops_r_in;
         bhops_d_ff <= bhops_d_in;
         ramp_ff <= ramp_in;
         acc_ff <= acc_in;
         sum_or_ff <= sum_or_in;
         sum_od_ff <= sum_od_in;
         sum_ir_ff <= sum_ir_in;
         sum_id_ff <= sum_id_in;
         sq_act_ff <= sq_act_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff <= idx_in;
      raw_ff <= raw_in;
      t_ff <= t_in;
      jidx_ff <= jidx_in;
      m_r_ff <= m_r_in;
      m_d_ff <= m_d_in;
      mi_r_ff <= mi_r_in;
      mi_d_ff <= mi_d_in;
      ad_r_ff <= ad_r_in;
      ad_d_ff <= ad_d_in;
      ss_r_ff <= ss_r_in;
      ss_d_ff <= ss_d_in;
      jit_r_ff <= jit_r_in;
      jit_d_ff <= jit_d_in;
      sq_cnt_ff <= sq_cnt_in;
      sq_val_ff <= sq_val_in;
      sq_rem_ff <= sq_rem_in;
      sq_root_ff <= sq_root_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   fta_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   fta_ram #(
      .WIDTH (2 * CORR_W),
      .DEPTH (MAX_BLOCK)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (acc_ff[AW-1:0]),
      .wdata (ram_wdata),
      .raddr (jidx_ff[AW-1:0]),
      .rdata (ram_rdata)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule
